// ===== sv/ebeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebeq_pkg
// Types and constants shared by the encoder / button event qualifier.
// ----------------------------------------------------------------------------
package ebeq_pkg;

  localparam int unsigned LockW = 24;

  // Item kinds on the input channel
  localparam logic [1:0] ACT_ENC  = 2'd0;
  localparam logic [1:0] ACT_BTN  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Encoder A/B patterns
  localparam logic [1:0] AB_IDLE = 2'd3;
  localparam logic [1:0] AB_A    = 2'd1;
  localparam logic [1:0] AB_B    = 2'd2;

  // Rotation direction tracking
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Event codes
  localparam logic [2:0] EV_UP       = 3'd0;
  localparam logic [2:0] EV_DOWN     = 3'd1;
  localparam logic [2:0] EV_CLICK    = 3'd2;
  localparam logic [2:0] EV_BTN_UP   = 3'd3;
  localparam logic [2:0] EV_BTN_LEFT = 3'd4;
  localparam logic [2:0] EV_BTN_RGT  = 3'd5;
  localparam logic [2:0] EV_BTN_DOWN = 3'd6;
  localparam logic [2:0] EV_BTN_CTR  = 3'd7;

  localparam logic [LockW-1:0] LOCKOUT_RST = 24'd2000000;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] enc_pins;
    logic [4:0] btn_pins;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       last;
  } out_item_t;

endpackage

// ===== sv/encoder_button_event_qualifier.sv =====
`timescale 1ns / 1ps
// Latency: results of an item appear on out_item the cycle after it is accepted.
// Throughput: one item per cycle while out_stall is low; an encoder item
// with both a click and a rotation event fills two slots, stalling the next.
// Reset (synchronous, rst_n low): encoder idle, no lockout, lockout length
// 2000000 ticks, result queue empty.
// ----------------------------------------------------------------------------
// encoder_button_event_qualifier
// Quadrature step decoding plus click/button edge qualification with a shared
// tick-based debounce lockout; results go through a two-slot output register.
// ----------------------------------------------------------------------------
module encoder_button_event_qualifier
  import ebeq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  // result items
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  // lockout length register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LockW-1:0] cfg_data
);

  logic [LockW-1:0] lock_ticks_r;
  logic [1:0]       enc_prev_r, enc_prev_nxt;
  logic [1:0]       rot_dir_r, rot_dir_nxt;
  logic             click_prev_r, click_prev_nxt;
  logic [4:0]       btn_prev_r, btn_prev_nxt;
  logic             accept_en_r, accept_en_nxt;
  logic [LockW-1:0] lock_left_r, lock_left_nxt;

  out_item_t        q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  logic             in_acc, out_pop;
  logic             click, click_ev, rot_ev, btn_ev, start_lock;
  logic [1:0]       ab;
  logic [2:0]       rot_code, btn_code;
  logic [1:0]       res_n;
  out_item_t        res0, res1;

  assign cfg_ready = 1'b1;
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = q0_r;
  assign out_pop   = out_valid && !out_stall;
  // room when empty, or holding one that leaves this cycle
  assign in_stall  = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_pop));
  assign in_acc    = in_valid && !in_stall;

  assign click = in_item.enc_pins[2];
  assign ab    = in_item.enc_pins[1:0];

  // one-hot button pattern to event code
  always_comb begin
    btn_ev   = 1'b1;
    btn_code = EV_BTN_UP;
    case (in_item.btn_pins)
      5'b00001: btn_code = EV_BTN_UP;
      5'b00010: btn_code = EV_BTN_LEFT;
      5'b00100: btn_code = EV_BTN_RGT;
      5'b01000: btn_code = EV_BTN_DOWN;
      5'b10000: btn_code = EV_BTN_CTR;
      default:  btn_ev   = 1'b0;
    endcase
  end

  // per-item state update and event detection
  always_comb begin
    enc_prev_nxt   = enc_prev_r;
    rot_dir_nxt    = rot_dir_r;
    click_prev_nxt = click_prev_r;
    btn_prev_nxt   = btn_prev_r;
    accept_en_nxt  = accept_en_r;
    lock_left_nxt  = lock_left_r;
    click_ev       = 1'b0;
    rot_ev         = 1'b0;
    rot_code       = EV_UP;
    start_lock     = 1'b0;
    res_n          = 2'd0;
    res0           = '{event_res: EV_UP, last: 1'b1};
    res1           = '{event_res: EV_UP, last: 1'b1};
    if (in_acc) begin
      case (in_item.action)
        ACT_ENC: begin
          if ((click != click_prev_r) && accept_en_r) begin
            start_lock = 1'b1;
            click_ev   = click;
          end
          click_prev_nxt = click;
          case (ab)
            AB_IDLE: begin
              if ((enc_prev_r == AB_B) && (rot_dir_r == DIR_UP)) begin
                rot_ev   = 1'b1;
                rot_code = EV_UP;
              end else if ((enc_prev_r == AB_A) && (rot_dir_r == DIR_DOWN)) begin
                rot_ev   = 1'b1;
                rot_code = EV_DOWN;
              end
              rot_dir_nxt = DIR_NONE;
            end
            AB_A: if (enc_prev_r == AB_IDLE) rot_dir_nxt = DIR_UP;
            AB_B: if (enc_prev_r == AB_IDLE) rot_dir_nxt = DIR_DOWN;
            default: ;
          endcase
          enc_prev_nxt = ab;
        end
        ACT_BTN: begin
          if (in_item.btn_pins != btn_prev_r) begin
            btn_prev_nxt = in_item.btn_pins;
            if (accept_en_r) begin
              start_lock = 1'b1;
            end
          end
        end
        ACT_TICK: begin
          if (lock_left_r != '0) begin
            lock_left_nxt = lock_left_r - 1'b1;
            if (lock_left_r == {{(LockW-1){1'b0}}, 1'b1}) accept_en_nxt = 1'b1;
          end
        end
        default: ;
      endcase
      if (start_lock) begin
        accept_en_nxt = 1'b0;
        lock_left_nxt = (lock_ticks_r != '0) ? lock_ticks_r
                                             : {{(LockW-1){1'b0}}, 1'b1};
      end
      // order results: click before rotation
      if (in_item.action == ACT_BTN) begin
        if (start_lock && btn_ev) begin
          res_n = 2'd1;
          res0  = '{event_res: btn_code, last: 1'b1};
        end
      end else if (click_ev && rot_ev) begin
        res_n = 2'd2;
        res0  = '{event_res: EV_CLICK, last: 1'b0};
        res1  = '{event_res: rot_code, last: 1'b1};
      end else if (click_ev) begin
        res_n = 2'd1;
        res0  = '{event_res: EV_CLICK, last: 1'b1};
      end else if (rot_ev) begin
        res_n = 2'd1;
        res0  = '{event_res: rot_code, last: 1'b1};
      end
    end
  end

  // two-slot result queue
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      q0_nxt  = res0;
      q1_nxt  = res1;
      cnt_nxt = res_n;
    end else if (out_pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_ticks_r <= LOCKOUT_RST;
      enc_prev_r   <= AB_IDLE;
      rot_dir_r    <= DIR_NONE;
      click_prev_r <= 1'b0;
      btn_prev_r   <= '0;
      accept_en_r  <= 1'b1;
      lock_left_r  <= '0;
      cnt_r        <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) lock_ticks_r <= cfg_data;
      enc_prev_r   <= enc_prev_nxt;
      rot_dir_r    <= rot_dir_nxt;
      click_prev_r <= click_prev_nxt;
      btn_prev_r   <= btn_prev_nxt;
      accept_en_r  <= accept_en_nxt;
      lock_left_r  <= lock_left_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result queue count out of range");

  a_lock_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (lock_left_r != '0) |-> !accept_en_r) else $error("lockout running while accepting");

  a_not_last_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> (cnt_r == 2'd2))
    else $error("non-final result without a follower");

  a_btn_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_item.action == ACT_BTN)) |=> (cnt_r != 2'd2))
    else $error("button item gave two results");
`endif

endmodule
